FILE: design/green_frame_box_refine_unit_defines.svh
// Assertion macros shared by the frame box refine RTL.
`ifndef GREEN_FRAME_BOX_REFINE_UNIT_DEFINES_SVH
`define GREEN_FRAME_BOX_REFINE_UNIT_DEFINES_SVH

// same-cycle implication
`define GFBR_ASSERT_NOW(label, clk, rst, cond, consq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (consq)) \
    else $error("gfbr check failed");

// next-cycle implication
`define GFBR_ASSERT_NEXT(label, clk, rst, cond, consq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (consq)) \
    else $error("gfbr check failed");

`endif

FILE: design/gfbr_pkg.sv
// Shared widths, defaults and FSM type for the frame box refine block.
package gfbr_pkg;

  localparam int REGION_X_W      = 12;
  localparam int REGION_Y_W      = 12;
  localparam int REGION_WIDTH_W  = 10;
  localparam int REGION_HEIGHT_W = 9;
  localparam int GREEN_W         = 8;
  localparam int BOX_LEFT_W      = 13;
  localparam int BOX_TOP_W       = 13;
  localparam int BOX_WIDTH_W     = 10;
  localparam int BOX_HEIGHT_W    = 9;

  localparam int MAX_BOX_WIDTH_DEF  = 512;
  localparam int MAX_BOX_HEIGHT_DEF = 256;

  localparam logic [GREEN_W-1:0] GREEN_THRESHOLD_RESET = 8'd160;

  // mask bits handled per cycle in row sums and edge searches
  localparam int CHUNK_W     = 32;
  localparam int CHUNK_IDX_W = $clog2(CHUNK_W);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_ROW_RD,
    ST_ROW_CAP,
    ST_ROW_SUM,
    ST_ROW_EVAL,
    ST_LEFT_FLAG,
    ST_LEFT_SRCH,
    ST_PASS_B,
    ST_RIGHT_FLAG,
    ST_RIGHT_SRCH,
    ST_DONE
  } state_t;

endpackage

FILE: design/gfbr_if.sv
// Valid/ready channel interfaces for pixel words and refined box words.
interface gfbr_pixel_if;
  logic                                   valid;
  logic                                   ready;
  logic [gfbr_pkg::REGION_X_W-1:0]        region_x;
  logic [gfbr_pkg::REGION_Y_W-1:0]        region_y;
  logic [gfbr_pkg::REGION_WIDTH_W-1:0]    region_width;
  logic [gfbr_pkg::REGION_HEIGHT_W-1:0]   region_height;
  logic [gfbr_pkg::GREEN_W-1:0]           green_value;
  logic                                   last_pixel;

  modport source (
    output valid, region_x, region_y, region_width, region_height, green_value, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, region_x, region_y, region_width, region_height, green_value, last_pixel,
    output ready
  );
endinterface

interface gfbr_box_if;
  logic                                valid;
  logic                                ready;
  logic [gfbr_pkg::BOX_LEFT_W-1:0]     box_left;
  logic [gfbr_pkg::BOX_TOP_W-1:0]      box_top;
  logic [gfbr_pkg::BOX_WIDTH_W-1:0]    box_width;
  logic [gfbr_pkg::BOX_HEIGHT_W-1:0]   box_height;

  modport source (
    output valid, box_left, box_top, box_width, box_height,
    input  ready
  );
  modport sink (
    input  valid, box_left, box_top, box_width, box_height,
    output ready
  );
endinterface

FILE: design/gfbr_ram.sv
// Generic simple dual-port RAM with registered read data.
module gfbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/green_frame_box_refine_unit.sv
// Top level of the frame box refine block: mask store, row passes and edge searches.
`include "green_frame_box_refine_unit_defines.svh"

// Each pixel word is taken in the idle state, which reads the mask row it falls in from the
// mask RAM; the write state writes it back with the pixel's bit (green above threshold)
// replaced. On the word marked last the block refines the box and stops taking pixels until
// the result word is registered. Refinement runs two passes over the stored rows, one row
// read per visit; each row is read, captured, summed in 32-bit chunks and evaluated. The
// first pass visits all h rows (column counts and the top edge), the second the rows below
// the top (column counts and the bottom edge). The left and right edges come from searches
// over the per-column flags, 32 columns a cycle. The result sits in an output register; the
// next box loads while it waits to be taken.
module green_frame_box_refine_unit #(
  parameter int MAX_BOX_WIDTH  = gfbr_pkg::MAX_BOX_WIDTH_DEF,
  parameter int MAX_BOX_HEIGHT = gfbr_pkg::MAX_BOX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [gfbr_pkg::GREEN_W-1:0] cfg_wr_data,
  gfbr_pixel_if.sink                   pixel,
  gfbr_box_if.source                   box
);

  localparam int CHUNK_W = gfbr_pkg::CHUNK_W;
  localparam int CIW     = gfbr_pkg::CHUNK_IDX_W;
  localparam int GW      = gfbr_pkg::GREEN_W;
  localparam int XW      = gfbr_pkg::REGION_X_W;
  localparam int YW      = gfbr_pkg::REGION_Y_W;
  localparam int LW      = gfbr_pkg::BOX_LEFT_W;
  localparam int TW      = gfbr_pkg::BOX_TOP_W;
  localparam int BXW     = gfbr_pkg::BOX_WIDTH_W;
  localparam int BYW     = gfbr_pkg::BOX_HEIGHT_W;
  localparam int CW      = $clog2(MAX_BOX_WIDTH);
  localparam int WW      = $clog2(MAX_BOX_WIDTH + 1);
  localparam int RW      = $clog2(MAX_BOX_HEIGHT);
  localparam int HW      = $clog2(MAX_BOX_HEIGHT + 1);
  localparam int NCH     = (MAX_BOX_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W   = NCH * CHUNK_W;
  localparam int BW      = $clog2(PAD_W);
  localparam int BW1     = BW + 1;
  localparam int CBW     = $clog2(PAD_W + 1);
  localparam logic [BW-1:0] LAST_BASE = BW'(PAD_W - CHUNK_W);
  localparam logic [RW-1:0] ROW_LAST  = RW'(MAX_BOX_HEIGHT - 1);

  gfbr_pkg::state_t state, state_next;

  logic [GW-1:0]            threshold;
  logic [XW-1:0]            org_x;
  logic [YW-1:0]            org_y;
  logic [WW-1:0]            w_reg;
  logic [HW-1:0]            h_reg;
  logic [GW-1:0]            green;
  logic                     last_reg;
  logic [CW-1:0]            load_column;
  logic [RW-1:0]            load_row;

  logic                     pass_b;
  logic [HW-1:0]            scan_row;
  logic [MAX_BOX_WIDTH-1:0] col_mask;
  logic [PAD_W-1:0]         row_buf;
  logic [CBW-1:0]           col_base;
  logic [WW-1:0]            pc;
  logic [HW-1:0]            col_cnt [MAX_BOX_WIDTH];
  logic [CW-1:0]            l_reg;
  logic [RW-1:0]            t_reg;
  logic                     t_found;
  logic [WW-1:0]            rr_reg;
  logic [HW-1:0]            bb_reg;
  logic [PAD_W-1:0]         srch;
  logic [BW-1:0]            srch_base;

  logic                     mem_we;
  logic                     mem_re;
  logic [RW-1:0]            mem_raddr;
  logic [MAX_BOX_WIDTH-1:0] mem_wdata;
  logic [MAX_BOX_WIDTH-1:0] mem_rdata;
  logic [MAX_BOX_WIDTH-1:0] masked_row;

  logic                     accept;
  logic                     out_load;
  logic [WW-1:0]            w_in;
  logic [HW-1:0]            h_in;
  logic                     frame_bit;
  logic [CIW:0]             chunk_cnt;
  logic                     row_end;
  logic [WW-1:0]            w_minus_l;
  logic [HW-1:0]            h_minus_t;
  logic [WW+3:0]            pc_x10;
  logic [WW+3:0]            wl_x7;
  logic [HW+3:0]            ht_x7;
  logic                     row_top_hit;
  logic                     row_bot_hit;
  logic [PAD_W-1:0]         left_flags;
  logic [PAD_W-1:0]         right_flags;
  logic [CHUNK_W-1:0]       lo_chunk;
  logic [CHUNK_W-1:0]       hi_chunk;
  logic                     lo_any;
  logic                     hi_any;
  logic [CW-1:0]            found_lo;
  logic [WW-1:0]            found_hi;
  logic [WW-1:0]            l_wide;
  logic [HW-1:0]            t_wide;

  function automatic logic [CIW-1:0] lowest_one(input logic [CHUNK_W-1:0] v);
    logic [CIW-1:0] k;
    k = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (v[i]) k = CIW'(i);
    end
    return k;
  endfunction

  function automatic logic [CIW-1:0] highest_one(input logic [CHUNK_W-1:0] v);
    logic [CIW-1:0] k;
    k = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      if (v[i]) k = CIW'(i);
    end
    return k;
  endfunction

  gfbr_ram #(
    .WIDTH (MAX_BOX_WIDTH),
    .DEPTH (MAX_BOX_HEIGHT)
  ) u_mask_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (load_row),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign accept    = pixel.valid && pixel.ready;
  assign w_in      = (32'(pixel.region_width) > 32'(MAX_BOX_WIDTH)) ?
                     WW'(MAX_BOX_WIDTH) : WW'(pixel.region_width);
  assign h_in      = (32'(pixel.region_height) > 32'(MAX_BOX_HEIGHT)) ?
                     HW'(MAX_BOX_HEIGHT) : HW'(pixel.region_height);
  assign frame_bit = green > threshold;

  // merge the new pixel bit into the row just read
  always_comb begin
    for (int c = 0; c < MAX_BOX_WIDTH; c++) begin
      mem_wdata[c] = (CW'(c) == load_column) ? frame_bit : mem_rdata[c];
    end
  end

  assign masked_row = mem_rdata & col_mask;
  assign chunk_cnt  = (CIW + 1)'($countones(row_buf[CHUNK_W-1:0]));
  assign row_end    = (32'(col_base) + CHUNK_W) >= 32'(w_reg);

  assign l_wide      = WW'(l_reg);
  assign t_wide      = HW'(t_reg);
  assign w_minus_l   = w_reg - l_wide;
  assign h_minus_t   = h_reg - t_wide;
  assign pc_x10      = (WW + 4)'({pc, 3'b000}) + (WW + 4)'({pc, 1'b0});
  assign wl_x7       = (WW + 4)'({w_minus_l, 3'b000}) - (WW + 4)'(w_minus_l);
  assign ht_x7       = (HW + 4)'({h_minus_t, 3'b000}) - (HW + 4)'(h_minus_t);
  assign row_top_hit = {pc, 1'b0} > {1'b0, w_reg};
  assign row_bot_hit = pc_x10 > wl_x7;

  // per-column edge tests; counters outside the masked span stay zero
  always_comb begin
    left_flags  = '0;
    right_flags = '0;
    for (int c = 0; c < MAX_BOX_WIDTH; c++) begin
      left_flags[c]  = {col_cnt[c], 1'b0} > {1'b0, h_reg};
      right_flags[c] = ((HW + 4)'({col_cnt[c], 3'b000}) +
                        (HW + 4)'({col_cnt[c], 1'b0})) > ht_x7;
    end
  end

  assign lo_chunk = srch[CHUNK_W-1:0];
  assign hi_chunk = srch[PAD_W-1 -: CHUNK_W];
  assign lo_any   = |lo_chunk;
  assign hi_any   = |hi_chunk;
  assign found_lo = CW'(BW1'(srch_base) + BW1'(lowest_one(lo_chunk)));
  assign found_hi = WW'(BW1'(srch_base) + BW1'(highest_one(hi_chunk)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gfbr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    pixel.ready = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_raddr   = load_row;
    out_load    = 1'b0;
    case (state)
      gfbr_pkg::ST_IDLE: begin
        // no words taken while reset is held
        pixel.ready = !rst;
        mem_re      = 1'b1;
        if (pixel.valid) state_next = gfbr_pkg::ST_WRITE;
      end
      gfbr_pkg::ST_WRITE: begin
        mem_we     = 1'b1;
        state_next = last_reg ? gfbr_pkg::ST_ROW_RD : gfbr_pkg::ST_IDLE;
      end
      gfbr_pkg::ST_ROW_RD: begin
        if (scan_row < h_reg) begin
          mem_re     = 1'b1;
          mem_raddr  = scan_row[RW-1:0];
          state_next = gfbr_pkg::ST_ROW_CAP;
        end else begin
          state_next = pass_b ? gfbr_pkg::ST_RIGHT_FLAG : gfbr_pkg::ST_LEFT_FLAG;
        end
      end
      gfbr_pkg::ST_ROW_CAP:   state_next = gfbr_pkg::ST_ROW_SUM;
      gfbr_pkg::ST_ROW_SUM: begin
        if (row_end) state_next = gfbr_pkg::ST_ROW_EVAL;
      end
      gfbr_pkg::ST_ROW_EVAL:  state_next = gfbr_pkg::ST_ROW_RD;
      gfbr_pkg::ST_LEFT_FLAG: state_next = gfbr_pkg::ST_LEFT_SRCH;
      gfbr_pkg::ST_LEFT_SRCH: begin
        if (lo_any || (srch_base == LAST_BASE)) state_next = gfbr_pkg::ST_PASS_B;
      end
      gfbr_pkg::ST_PASS_B:     state_next = gfbr_pkg::ST_ROW_RD;
      gfbr_pkg::ST_RIGHT_FLAG: state_next = gfbr_pkg::ST_RIGHT_SRCH;
      gfbr_pkg::ST_RIGHT_SRCH: begin
        if (hi_any || (srch_base == '0)) state_next = gfbr_pkg::ST_DONE;
      end
      gfbr_pkg::ST_DONE: begin
        if (!box.valid || box.ready) begin
          out_load   = 1'b1;
          state_next = gfbr_pkg::ST_IDLE;
        end
      end
      default: state_next = gfbr_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= gfbr_pkg::GREEN_THRESHOLD_RESET;
      load_column <= '0;
      load_row    <= '0;
      box.valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) threshold <= cfg_wr_data;

      if (out_load) begin
        box.valid <= 1'b1;
      end else if (box.ready) begin
        box.valid <= 1'b0;
      end

      if (state == gfbr_pkg::ST_WRITE) begin
        if (last_reg) begin
          load_column <= '0;
          load_row    <= '0;
        end else if ((WW'(load_column) + WW'(1)) >= w_reg) begin
          load_column <= '0;
          load_row    <= (load_row == ROW_LAST) ? '0 : load_row + RW'(1);
        end else begin
          load_column <= load_column + CW'(1);
        end
      end
    end
  end

  // pixel capture, row passes and edge searches
  always_ff @(posedge clk) begin
    case (state)
      gfbr_pkg::ST_IDLE: begin
        if (accept) begin
          org_x    <= pixel.region_x;
          org_y    <= pixel.region_y;
          w_reg    <= w_in;
          h_reg    <= h_in;
          green    <= pixel.green_value;
          last_reg <= pixel.last_pixel;
        end
      end
      gfbr_pkg::ST_WRITE: begin
        if (last_reg) begin
          pass_b   <= 1'b0;
          scan_row <= '0;
          t_reg    <= '0;
          t_found  <= 1'b0;
          for (int c = 0; c < MAX_BOX_WIDTH; c++) begin
            col_mask[c] <= WW'(c) < w_reg;
            col_cnt[c]  <= '0;
          end
        end
      end
      gfbr_pkg::ST_ROW_CAP: begin
        row_buf  <= PAD_W'(masked_row);
        col_base <= '0;
        pc       <= '0;
        for (int c = 0; c < MAX_BOX_WIDTH; c++) begin
          col_cnt[c] <= col_cnt[c] + HW'(masked_row[c]);
        end
      end
      gfbr_pkg::ST_ROW_SUM: begin
        row_buf  <= row_buf >> CHUNK_W;
        col_base <= col_base + CBW'(CHUNK_W);
        pc       <= pc + WW'(chunk_cnt);
      end
      gfbr_pkg::ST_ROW_EVAL: begin
        if (!pass_b) begin
          // top edge: first qualifying row wins
          if (!t_found && row_top_hit) begin
            t_reg   <= scan_row[RW-1:0];
            t_found <= 1'b1;
          end
        end else if (row_bot_hit) begin
          // bottom edge: rows go upward in index, so the last hit is the lowest row
          bb_reg <= scan_row;
        end
        scan_row <= scan_row + HW'(1);
      end
      gfbr_pkg::ST_LEFT_FLAG: begin
        srch      <= left_flags;
        srch_base <= '0;
        l_reg     <= '0;
      end
      gfbr_pkg::ST_LEFT_SRCH: begin
        if (lo_any) begin
          l_reg <= found_lo;
        end else begin
          srch      <= srch >> CHUNK_W;
          srch_base <= srch_base + BW'(CHUNK_W);
        end
      end
      gfbr_pkg::ST_PASS_B: begin
        pass_b   <= 1'b1;
        scan_row <= t_wide + HW'(1);
        bb_reg   <= h_reg;
        for (int c = 0; c < MAX_BOX_WIDTH; c++) begin
          col_mask[c] <= (WW'(c) < w_reg) && (CW'(c) > l_reg);
          col_cnt[c]  <= '0;
        end
      end
      gfbr_pkg::ST_RIGHT_FLAG: begin
        srch      <= right_flags;
        srch_base <= LAST_BASE;
        rr_reg    <= w_reg;
      end
      gfbr_pkg::ST_RIGHT_SRCH: begin
        if (hi_any) begin
          rr_reg <= found_hi;
        end else begin
          srch      <= srch << CHUNK_W;
          srch_base <= srch_base - BW'(CHUNK_W);
        end
      end
      gfbr_pkg::ST_DONE: begin
        if (out_load) begin
          box.box_left   <= LW'(org_x) + LW'(l_reg);
          box.box_top    <= TW'(org_y) + TW'(t_reg);
          box.box_width  <= BXW'(rr_reg - l_wide);
          box.box_height <= BYW'(bb_reg - t_wide);
        end
      end
      default: ;
    endcase
  end

  `GFBR_ASSERT_NEXT(a_load_pos_home, clk, rst, (state == gfbr_pkg::ST_WRITE) && last_reg, (load_column == '0) && (load_row == '0))
  `GFBR_ASSERT_NOW(a_right_span, clk, rst, out_load, (l_wide <= rr_reg) && (rr_reg <= w_reg))
  `GFBR_ASSERT_NOW(a_bottom_span, clk, rst, out_load, (t_wide <= bb_reg) && (bb_reg <= h_reg))

endmodule

FILE: dv/tb_green_frame_box_refine_unit.sv
// Self-checking testbench for the green frame box refine unit.
`timescale 1ns / 1ps

module tb_green_frame_box_refine_unit;

  localparam int MAXW        = gfbr_pkg::MAX_BOX_WIDTH_DEF;
  localparam int MAXH        = gfbr_pkg::MAX_BOX_HEIGHT_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int XW          = gfbr_pkg::REGION_X_W;
  localparam int YW          = gfbr_pkg::REGION_Y_W;
  localparam int WDW         = gfbr_pkg::REGION_WIDTH_W;
  localparam int HTW         = gfbr_pkg::REGION_HEIGHT_W;
  localparam int GW          = gfbr_pkg::GREEN_W;
  localparam int LW          = gfbr_pkg::BOX_LEFT_W;
  localparam int TW          = gfbr_pkg::BOX_TOP_W;
  localparam int BXW         = gfbr_pkg::BOX_WIDTH_W;
  localparam int BYW         = gfbr_pkg::BOX_HEIGHT_W;

  typedef enum {FILL_NOISE, FILL_OUTLINE, FILL_FILLED, FILL_ALL_HI, FILL_ALL_LO} fill_mode_t;

  typedef struct {
    logic [XW-1:0]  region_x;
    logic [YW-1:0]  region_y;
    logic [WDW-1:0] region_width;
    logic [HTW-1:0] region_height;
    logic [GW-1:0]  green_value;
    logic           last_pixel;
    bit             wait_drain;
  } pixel_word_t;

  typedef struct {
    logic [LW-1:0]  box_left;
    logic [TW-1:0]  box_top;
    logic [BXW-1:0] box_width;
    logic [BYW-1:0] box_height;
  } box_word_t;

  logic           clk;
  logic           rst;
  logic           cfg_wr_en;
  logic [GW-1:0]  cfg_wr_data;

  gfbr_pixel_if pixel_ch ();
  gfbr_box_if   box_ch ();

  green_frame_box_refine_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pixel       (pixel_ch),
    .box         (box_ch)
  );

  // predictor state
  bit [MAXW-1:0] frame_bits [MAXH];
  int            ld_col;
  int            ld_row;
  int            green_thr;
  box_word_t     box_expect_q [$];

  // stimulus side: load position and which mask cells have been written
  bit [MAXW-1:0] gen_seen [MAXH];
  int            gen_col;
  int            gen_row;
  pixel_word_t   pixel_pending_q [$];
  pixel_word_t   cur_word;

  int n_pushed;
  int n_accepted;
  int n_predicted;
  int n_received;
  int n_errors;
  int cycle_count;
  int send_idle_pct;
  int stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic box_word_t refine_box(int ox, int oy, int w, int h);
    box_word_t res;
    int l, t, rr, bb, cnt;
    l = 0;
    for (int c = 0; c < w; c++) begin
      cnt = 0;
      for (int r = 0; r < h; r++) cnt += frame_bits[r][c];
      if (2 * cnt > h) begin
        l = c;
        break;
      end
    end
    t = 0;
    for (int r = 0; r < h; r++) begin
      cnt = 0;
      for (int c = 0; c < w; c++) cnt += frame_bits[r][c];
      if (2 * cnt > w) begin
        t = r;
        break;
      end
    end
    // right edge: scan inward, count only rows below the top edge
    rr = w;
    for (int c = w; c > l + 1; c--) begin
      cnt = 0;
      for (int r = t + 1; r < h; r++) cnt += frame_bits[r][c-1];
      if (10 * cnt > 7 * (h - t)) begin
        rr = c - 1;
        break;
      end
    end
    bb = h;
    for (int r = h; r > t + 1; r--) begin
      cnt = 0;
      for (int c = l + 1; c < w; c++) cnt += frame_bits[r-1][c];
      if (10 * cnt > 7 * (w - l)) begin
        bb = r - 1;
        break;
      end
    end
    res.box_left   = LW'(ox + l);
    res.box_top    = TW'(oy + t);
    res.box_width  = BXW'(rr - l);
    res.box_height = BYW'(bb - t);
    return res;
  endfunction

  task automatic take_pixel(pixel_word_t pw);
    int w, h;
    w = (pw.region_width > MAXW) ? MAXW : pw.region_width;
    h = (pw.region_height > MAXH) ? MAXH : pw.region_height;
    if (ld_row < MAXH && ld_col < MAXW) frame_bits[ld_row][ld_col] = (pw.green_value > green_thr);
    if (ld_col + 1 >= w) begin
      ld_col = 0;
      ld_row = (ld_row + 1) % MAXH;
    end else begin
      ld_col++;
    end
    if (pw.last_pixel) begin
      ld_col = 0;
      ld_row = 0;
      box_expect_q.insert(box_expect_q.size(), refine_box(pw.region_x, pw.region_y, w, h));
      n_predicted++;
    end
  endtask

  function automatic int pick_green(bit hi);
    if (hi) return (green_thr < 255) ? $urandom_range(255, green_thr + 1) : 255;
    return $urandom_range(green_thr, 0);
  endfunction

  // Queue one box. Pixels keep coming past n until every mask cell the
  // refinement may read has been written at least once since reset.
  task automatic add_box(int ox, int oy, int wf, int hf, int n, fill_mode_t mode,
                         bit broken, bit hold);
    pixel_word_t pw;
    int rw, rh, holes, i, pl, pr, pt, pb, r, c, wi, wsat;
    bit in_shape, last, noisy;
    rw = (wf > MAXW) ? MAXW : wf;
    rh = (hf > MAXH) ? MAXH : hf;
    holes = 0;
    for (int y = 0; y < rh; y++)
      for (int x = 0; x < rw; x++)
        if (!gen_seen[y][x]) holes++;
    pl = 0; pr = 0; pt = 0; pb = 0;
    if (rw > 0) begin
      pl = $urandom_range(1, 0) ? 0 : $urandom_range(rw - 1, 0);
      pr = $urandom_range(1, 0) ? rw - 1 : $urandom_range(rw - 1, pl);
    end
    if (rh > 0) begin
      pt = $urandom_range(1, 0) ? 0 : $urandom_range(rh - 1, 0);
      pb = $urandom_range(1, 0) ? rh - 1 : $urandom_range(rh - 1, pt);
    end
    i = 0;
    last = 0;
    while (!last) begin
      r = gen_row;
      c = gen_col;
      noisy = broken && (i < n - 1);
      wi = noisy ? $urandom_range(40, 0) : wf;
      if (r < rh && c < rw && !gen_seen[r][c]) holes--;
      gen_seen[r][c] = 1'b1;
      last = (i >= n - 1) && (holes == 0);
      case (mode)
        FILL_OUTLINE: in_shape = (r >= pt && r <= pb && (c == pl || c == pr)) ||
                                 (c >= pl && c <= pr && (r == pt || r == pb));
        FILL_FILLED:  in_shape = r >= pt && r <= pb && c >= pl && c <= pr;
        default:      in_shape = 1'b0;
      endcase
      if ($urandom_range(99, 0) < 5) in_shape = !in_shape;
      case (mode)
        FILL_NOISE:  pw.green_value = GW'($urandom_range(255, 0));
        FILL_ALL_HI: pw.green_value = GW'(255);
        FILL_ALL_LO: pw.green_value = '0;
        default:     pw.green_value = GW'(pick_green(in_shape));
      endcase
      pw.region_x      = XW'(noisy ? $urandom_range(4095, 0) : ox);
      pw.region_y      = YW'(noisy ? $urandom_range(4095, 0) : oy);
      pw.region_width  = WDW'(wi);
      pw.region_height = HTW'(noisy ? $urandom_range(511, 0) : hf);
      pw.last_pixel    = last;
      pw.wait_drain    = hold && (i == 0);
      pixel_pending_q.insert(pixel_pending_q.size(), pw);
      n_pushed++;
      wsat = (wi > MAXW) ? MAXW : wi;
      if (last) begin
        gen_col = 0;
        gen_row = 0;
      end else if (gen_col + 1 >= wsat) begin
        gen_col = 0;
        gen_row = (gen_row + 1) % MAXH;
      end else begin
        gen_col++;
      end
      i++;
    end
  endtask

  function automatic int pick_origin();
    case ($urandom_range(9, 0))
      0:       return 0;
      1:       return 4095;
      default: return $urandom_range(4095, 0);
    endcase
  endfunction

  task automatic add_random_box(bit hold);
    int wf, hf, n, area, s, m;
    fill_mode_t mode;
    bit oversized;
    oversized = 1'b0;
    s = $urandom_range(99, 0);
    if (s < 3) begin
      wf = $urandom_range(1023, 513);
      hf = $urandom_range(2, 0);
      oversized = 1'b1;
    end else if (s < 6) begin
      hf = $urandom_range(511, 257);
      wf = $urandom_range(2, 0);
      oversized = 1'b1;
    end else if (s < 9) begin
      wf = $urandom_range(1, 0) ? 0 : $urandom_range(24, 1);
      hf = (wf != 0) ? 0 : $urandom_range(16, 0);
    end else if (s < 15) begin
      wf = $urandom_range(64, 25);
      hf = $urandom_range(12, 1);
    end else if (s < 20) begin
      wf = $urandom_range(8, 1);
      hf = $urandom_range(48, 17);
    end else begin
      wf = $urandom_range(24, 1);
      hf = $urandom_range(16, 1);
    end
    area = ((wf > MAXW) ? MAXW : wf) * ((hf > MAXH) ? MAXH : hf);
    m = $urandom_range(99, 0);
    if (area == 0 || oversized) n = $urandom_range(16, 1);
    else if (m < 70) n = area;
    else if (m < 85) n = $urandom_range(area, 1);
    else n = area + $urandom_range(24, 1);
    m = $urandom_range(99, 0);
    if (m < 35) mode = FILL_OUTLINE;
    else if (m < 60) mode = FILL_FILLED;
    else if (m < 80) mode = FILL_NOISE;
    else if (m < 90) mode = FILL_ALL_HI;
    else mode = FILL_ALL_LO;
    add_box(pick_origin(), pick_origin(), wf, hf, n, mode, $urandom_range(99, 0) < 8, hold);
  endtask

  task automatic settle();
    wait (n_accepted == n_pushed && n_predicted == n_received);
    repeat (64) @(posedge clk);
  endtask

  task automatic run_phase(int thr_val, int s_pct, int r_pct);
    int boxes, start_px;
    settle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= GW'(thr_val);
    green_thr    = thr_val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    send_idle_pct = s_pct;
    stall_pct     = r_pct;
    boxes    = 0;
    start_px = n_pushed;
    while (n_pushed - start_px < 80) begin
      add_random_box(boxes == 1);
      boxes++;
    end
  endtask

  // pixel driver; the predictor runs on every accepted word
  always @(posedge clk) begin
    if (rst) begin
      pixel_ch.valid <= 1'b0;
    end else begin
      if (pixel_ch.valid && pixel_ch.ready) begin
        take_pixel(cur_word);
        n_accepted <= n_accepted + 1;
      end
      if (!pixel_ch.valid || pixel_ch.ready) begin
        if (pixel_pending_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct &&
            !(pixel_pending_q[0].wait_drain && n_predicted != n_received)) begin
          cur_word = pixel_pending_q.pop_front();
          pixel_ch.valid         <= 1'b1;
          pixel_ch.region_x      <= cur_word.region_x;
          pixel_ch.region_y      <= cur_word.region_y;
          pixel_ch.region_width  <= cur_word.region_width;
          pixel_ch.region_height <= cur_word.region_height;
          pixel_ch.green_value   <= cur_word.green_value;
          pixel_ch.last_pixel    <= cur_word.last_pixel;
        end else begin
          pixel_ch.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin : box_monitor
    box_word_t want;
    if (rst) begin
      box_ch.ready <= 1'b0;
    end else begin
      box_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
      if (box_ch.valid && box_ch.ready) begin
        if (box_expect_q.size() == 0) begin
          $error("box word with nothing expected: left %0d top %0d width %0d height %0d",
                 box_ch.box_left, box_ch.box_top, box_ch.box_width, box_ch.box_height);
          n_errors++;
        end else begin
          want = box_expect_q.pop_front();
          check_field("box_left", want.box_left, box_ch.box_left);
          check_field("box_top", want.box_top, box_ch.box_top);
          check_field("box_width", want.box_width, box_ch.box_width);
          check_field("box_height", want.box_height, box_ch.box_height);
        end
        n_received <= n_received + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst                    = 1'b1;
    cfg_wr_en              = 1'b0;
    cfg_wr_data            = '0;
    pixel_ch.valid         = 1'b0;
    pixel_ch.region_x      = '0;
    pixel_ch.region_y      = '0;
    pixel_ch.region_width  = '0;
    pixel_ch.region_height = '0;
    pixel_ch.green_value   = '0;
    pixel_ch.last_pixel    = 1'b0;
    box_ch.ready           = 1'b0;
    green_thr              = gfbr_pkg::GREEN_THRESHOLD_RESET;
    send_idle_pct          = 0;
    stall_pct              = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed boxes at the reset threshold
    add_box(0, 0, 1, 1, 1, FILL_ALL_HI, 0, 0);
    add_box(4095, 4095, 1, 1, 1, FILL_ALL_LO, 0, 0);
    add_box(0, 4095, 512, 1, 512, FILL_FILLED, 0, 0);
    add_box(4095, 0, 1023, 1, 5, FILL_NOISE, 0, 0);      // width saturates, short box
    add_box(17, 33, 1, 256, 256, FILL_OUTLINE, 0, 1);
    add_box(100, 200, 1, 511, 3, FILL_ALL_HI, 0, 0);     // height saturates
    add_box(5, 6, 0, 5, 4, FILL_NOISE, 0, 0);
    add_box(7, 8, 6, 0, 3, FILL_NOISE, 0, 0);
    add_box(9, 10, 0, 0, 2, FILL_ALL_HI, 0, 0);
    add_box(2048, 1024, 8, 6, 48, FILL_OUTLINE, 0, 0);
    add_box(1000, 3000, 8, 6, 48, FILL_FILLED, 0, 0);
    add_box(300, 400, 10, 4, 50, FILL_OUTLINE, 0, 0);    // extra pixels past the box
    add_box(11, 12, 1, 4, 300, FILL_NOISE, 0, 0);        // load row wraps
    add_box(13, 14, 12, 8, 40, FILL_FILLED, 1, 0);       // sizes change mid-box
    add_box(4095, 4095, 16, 16, 256, FILL_FILLED, 0, 0);

    run_phase(0, 0, 0);
    run_phase(255, 75, 0);
    run_phase($urandom_range(254, 1), 0, 75);
    run_phase($urandom_range(254, 1), 26, 26);
    run_phase(gfbr_pkg::GREEN_THRESHOLD_RESET, 0, 0);

    wait (n_accepted == n_pushed && n_predicted == n_received);
    repeat (200) @(posedge clk);
    if (box_expect_q.size() != 0) begin
      $error("%0d box words never arrived", box_expect_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/gfbr_pkg.sv
design/gfbr_if.sv
design/gfbr_ram.sv
design/green_frame_box_refine_unit.sv
dv/tb_green_frame_box_refine_unit.sv
